[hdl/brc_pkg.sv]
// Shared types and constants of the barrier row classifier.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package brc_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_JOINT  = 2'd0,
        FUNC_JAC    = 2'd1,
        FUNC_CLOSE  = 2'd2,
        FUNC_FINISH = 2'd3
    } brc_func_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATE_SCALE = 2'd0;
    localparam logic [1:0] CFG_CORR_THR   = 2'd1;
    localparam logic [1:0] CFG_HELD_LIMIT = 2'd2;

    // Saturation limits
    localparam logic [47:0] RATE_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DRAIN,
        ST_APPLY,
        ST_CLOSE,
        ST_EMIT_L,
        ST_EMIT_R
    } brc_state_t;

    // Alignment of a partial product before it joins the accumulator
    typedef enum logic [1:0] {
        SHIFT_RIGHT16,
        SHIFT_NONE,
        SHIFT_LEFT16
    } brc_shift_t;

    typedef struct packed {
        logic       clear;
        logic       mul_en;
        logic       acc_en;
        brc_shift_t shift;
    } brc_mac_ctrl_t;

    typedef struct packed {
        brc_mac_ctrl_t mac;
        logic          ld_prep;
        logic          apply_joint;
        logic          apply_jac;
        logic          close_row;
        logic          emit_l;
        logic          emit_r;
    } brc_seq_t;

    typedef struct packed {
        logic close;
        logic viol;
        logic clear;
    } brc_trk_ctrl_t;

    // Row presented to a tracker at close
    typedef struct packed {
        logic [31:0] headroom;
        logic [2:0]  klass;
        logic [15:0] pair;
    } brc_row_t;

    // Tracked row of one arm
    typedef struct packed {
        logic        valid;
        logic [31:0] headroom;
        logic [2:0]  klass;
        logic [15:0] pair;
    } brc_entry_t;

    // One arm's result item
    typedef struct packed {
        logic        has_row;
        logic        braking;
        logic        held;
        logic [7:0]  count;
        logic [31:0] headroom;
        logic [15:0] pair;
        logic [2:0]  klass;
    } brc_res_t;

endpackage

`default_nettype wire

[hdl/brc_mac.sv]
// Shared 33x16 multiply-accumulate unit, one partial product per cycle.
// Depends on brc_pkg for the control struct and shift codes.
`default_nettype none

module brc_mac (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire brc_pkg::brc_mac_ctrl_t ctrl,
    input  wire logic [32:0]            mul_a,
    input  wire logic [15:0]            mul_b,
    output logic [63:0]                 acc
);
    import brc_pkg::*;

    logic [48:0] prod_reg;
    logic [48:0] prod_next;
    brc_shift_t  shift_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] addend;

    // Multiplier, registered before the add
    assign prod_next = {16'd0, mul_a} * {33'd0, mul_b};

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_NONE;
            acc_reg   <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                shift_reg <= ctrl.shift;
            end
            acc_reg <= acc_next;
        end
    end

    // Align the product; the top slice never exceeds 15 bits, so bit 48 is zero there
    always_comb
    begin
        case (shift_reg)
            SHIFT_RIGHT16: addend = {31'd0, prod_reg[48:16]};
            SHIFT_NONE:    addend = {15'd0, prod_reg};
            SHIFT_LEFT16:  addend = {prod_reg[47:0], 16'd0};
            default:       addend = '0;
        endcase
    end

    // Accumulator
    always_comb
    begin
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + addend;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[hdl/brc_tracker.sv]
// Per-arm tracker: tightest row, tightest violated row, violation tally,
// and the result item built from them. Depends on brc_pkg.
`default_nettype none

module brc_tracker #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire brc_pkg::brc_trk_ctrl_t ctrl,
    input  wire brc_pkg::brc_row_t      row,
    input  wire logic                   ok,
    input  wire logic [31:0]            corr,
    input  wire logic [31:0]            corr_thr,
    input  wire logic [31:0]            held_limit,
    output brc_pkg::brc_res_t           result
);
    import brc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = {COUNT_WIDTH{1'b1}};

    brc_entry_t             eng_reg;
    brc_entry_t             eng_next;
    brc_entry_t             vio_reg;
    brc_entry_t             vio_next;
    logic [COUNT_WIDTH-1:0] tally_reg;
    logic [COUNT_WIDTH-1:0] tally_next;
    logic [COUNT_WIDTH+7:0] tally_ext;
    logic                   braking;
    logic                   has;
    brc_entry_t             shown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg   <= '0;
            vio_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            eng_reg   <= eng_next;
            vio_reg   <= vio_next;
            tally_reg <= tally_next;
        end
    end

    // Update on row close; strictly smaller headroom replaces, ties keep the first
    always_comb
    begin
        eng_next   = eng_reg;
        vio_next   = vio_reg;
        tally_next = tally_reg;
        if (ctrl.clear)
        begin
            eng_next   = '0;
            vio_next   = '0;
            tally_next = '0;
        end
        else if (ctrl.close)
        begin
            if (!eng_reg.valid || ($signed(row.headroom) < $signed(eng_reg.headroom)))
            begin
                eng_next = '{valid: 1'b1, headroom: row.headroom,
                             klass: row.klass, pair: row.pair};
            end
            if (ctrl.viol)
            begin
                if (tally_reg != TALLY_MAX)
                begin
                    tally_next = tally_reg + 1'b1;
                end
                if (!vio_reg.valid || ($signed(row.headroom) < $signed(vio_reg.headroom)))
                begin
                    vio_next = '{valid: 1'b1, headroom: row.headroom,
                                 klass: row.klass, pair: row.pair};
                end
            end
        end
    end

    // Result item
    assign tally_ext = {8'd0, tally_reg};
    assign braking   = ok && vio_reg.valid && ($signed(corr) > $signed(corr_thr));
    assign shown     = braking ? vio_reg : eng_reg;
    assign has       = ok && shown.valid;

    always_comb
    begin
        result.has_row  = has;
        result.braking  = braking;
        result.held     = braking && ($signed(vio_reg.headroom) <= $signed(held_limit));
        result.count    = ok ? tally_ext[7:0] : 8'd0;
        result.headroom = has ? shown.headroom : 32'd0;
        result.pair     = has ? shown.pair : 16'd0;
        result.klass    = has ? shown.klass : 3'd0;
    end

    // Checks
    a_vio_within_eng: assert property (@(posedge clk) disable iff (!rst_n)
        vio_reg.valid |-> (eng_reg.valid &&
                           ($signed(eng_reg.headroom) <= $signed(vio_reg.headroom))))
        else $error("violated row tracked without a tighter engaged row");

    a_tally_matches: assert property (@(posedge clk) disable iff (!rst_n)
        vio_reg.valid == (tally_reg != '0))
        else $error("violation tally out of step with violated row");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (!eng_reg.valid && !vio_reg.valid && (tally_reg == '0)))
        else $error("tracker not empty after clear");

endmodule

`default_nettype wire

[hdl/barrier_row_classifier_unit.sv]
// Joint and Jacobian items keep busy high through prepare, three passes of the
// shared 33x16 multiplier, drain and write back; close items through prepare and
// close; finish items through prepare and the left and right emit states, the
// left result strobed before the right. A new item is taken only while idle.
// Results cannot be stalled. Asynchronous reset clears config, joint rates,
// row accumulators and trackers. Depends on brc_pkg, brc_mac, brc_tracker.
`default_nettype none

module barrier_row_classifier_unit #(
    parameter int JOINTS_PER_ARM = 6,
    parameter int COUNT_WIDTH    = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  column,
    input  wire logic [31:0] prev_angle,
    input  wire logic [31:0] req_angle,
    input  wire logic [31:0] jac_value,
    input  wire logic [31:0] dist_now,
    input  wire logic [31:0] dist_hard,
    input  wire logic [31:0] closing_slack,
    input  wire logic [2:0]  row_class,
    input  wire logic [15:0] pair_id,
    input  wire logic [31:0] left_correction,
    input  wire logic [31:0] right_correction,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // result channel
    output logic             strobe,
    output logic             arm,
    output logic             has_row,
    output logic             braking,
    output logic             held,
    output logic [7:0]       violated_count,
    output logic [31:0]      headroom,
    output logic [15:0]      shown_pair,
    output logic [2:0]       shown_class,
    output logic             last
);
    import brc_pkg::*;

    localparam int         NCOLS     = 2 * JOINTS_PER_ARM;
    localparam int         IDXW      = $clog2(NCOLS);
    localparam logic [1:0] LAST_STEP = 2'd2;

    brc_state_t    state_reg;
    brc_state_t    state_next;
    logic [1:0]    step_reg;
    logic [1:0]    step_next;
    brc_seq_t      seq;
    logic          accept;

    // configuration
    logic [31:0]   rate_scale_reg;
    logic [31:0]   corr_thr_reg;
    logic [31:0]   held_limit_reg;

    // latched item
    brc_func_t     func_reg;
    logic [3:0]    col_reg;
    logic [32:0]   op_reg;
    logic [32:0]   op_next;
    logic [31:0]   slack_reg;
    logic [2:0]    klass_reg;
    logic [15:0]   pair_reg;
    logic [31:0]   lcorr_reg;
    logic [31:0]   rcorr_reg;

    // prepared operands
    logic [32:0]   a_reg;
    logic [47:0]   b_reg;
    logic          neg_reg;
    logic [31:0]   h_reg;
    logic          viol_reg;
    logic          op_neg;
    logic [32:0]   op_mag;
    logic [47:0]   jr_sel;
    logic [47:0]   jr_mag;
    logic [64:0]   slack_sum;

    // state
    logic [47:0]   joint_rate_reg [NCOLS];
    logic [63:0]   row_dot_reg;
    logic [1:0]    arm_nz_reg;

    // multiply-accumulate
    logic [15:0]   mul_b;
    logic [63:0]   acc;
    logic [47:0]   rate_mag;
    logic [47:0]   rate_new;
    logic [64:0]   dot_sum;
    logic [63:0]   dot_new;

    logic [IDXW-1:0] col_idx;
    logic          col_ok;
    logic          arm_sel;
    logic          row_keep;

    brc_trk_ctrl_t trk_ctrl_l;
    brc_trk_ctrl_t trk_ctrl_r;
    brc_row_t      trk_row;
    brc_res_t      res_l;
    brc_res_t      res_r;

    logic          strobe_reg;
    logic          arm_reg;
    logic          last_reg;
    brc_res_t      res_reg;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign col_idx   = col_reg[IDXW-1:0];
    assign col_ok    = ({1'b0, col_reg} < 5'(NCOLS));
    assign arm_sel   = ({1'b0, col_reg} >= 5'(JOINTS_PER_ARM));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg <= '0;
            corr_thr_reg   <= '0;
            held_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RATE_SCALE: rate_scale_reg <= cfg_data;
                CFG_CORR_THR:   corr_thr_reg   <= cfg_data;
                CFG_HELD_LIMIT: held_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            func_reg  <= FUNC_JOINT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
            begin
                func_reg <= brc_func_t'(func);
            end
        end
    end

    assign step_next = (state_reg == ST_MUL) ? step_reg + 2'd1 : 2'd0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                unique case (func_reg)
                    FUNC_JOINT, FUNC_JAC: state_next = col_ok ? ST_MUL : ST_IDLE;
                    FUNC_CLOSE:           state_next = ST_CLOSE;
                    FUNC_FINISH:          state_next = ST_EMIT_L;
                    default:              state_next = ST_IDLE;
                endcase
            end
            ST_MUL:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_IDLE;
            ST_CLOSE:  state_next = ST_IDLE;
            ST_EMIT_L: state_next = ST_EMIT_R;
            ST_EMIT_R: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        seq = '0;
        seq.mac.shift = SHIFT_NONE;
        unique case (state_reg)
            ST_IDLE:   ;
            ST_PREP:
            begin
                seq.ld_prep   = 1'b1;
                seq.mac.clear = 1'b1;
            end
            ST_MUL:
            begin
                seq.mac.mul_en = 1'b1;
                seq.mac.acc_en = (step_reg != 2'd0);
                case (step_reg)
                    2'd0:    seq.mac.shift = SHIFT_RIGHT16;
                    2'd1:    seq.mac.shift = SHIFT_NONE;
                    default: seq.mac.shift = SHIFT_LEFT16;
                endcase
            end
            ST_DRAIN:  seq.mac.acc_en = 1'b1;
            ST_APPLY:
            begin
                seq.apply_joint = (func_reg == FUNC_JOINT);
                seq.apply_jac   = (func_reg == FUNC_JAC);
            end
            ST_CLOSE:  seq.close_row = 1'b1;
            ST_EMIT_L: seq.emit_l    = 1'b1;
            ST_EMIT_R: seq.emit_r    = 1'b1;
            default:   ;
        endcase
    end

    // Item latch: a signed difference, the sign-extended Jacobian value, or zero
    always_comb
    begin
        unique case (brc_func_t'(func))
            FUNC_JOINT:  op_next = {req_angle[31], req_angle} - {prev_angle[31], prev_angle};
            FUNC_JAC:    op_next = {jac_value[31], jac_value};
            FUNC_CLOSE:  op_next = {dist_now[31], dist_now} - {dist_hard[31], dist_hard};
            default:     op_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg   <= column;
            op_reg    <= op_next;
            slack_reg <= closing_slack;
            klass_reg <= row_class;
            pair_reg  <= pair_id;
            lcorr_reg <= left_correction;
            rcorr_reg <= right_correction;
        end
    end

    // Operand preparation: magnitudes, product sign, headroom and violation test
    assign op_neg    = op_reg[32];
    assign op_mag    = op_neg ? (33'd0 - op_reg) : op_reg;
    assign jr_sel    = joint_rate_reg[col_idx];
    assign jr_mag    = jr_sel[47] ? (48'd0 - jr_sel) : jr_sel;
    assign slack_sum = {row_dot_reg[63], row_dot_reg}
                     + {{33{slack_reg[31]}}, slack_reg};

    always_ff @(posedge clk)
    begin
        if (seq.ld_prep)
        begin
            a_reg <= op_mag;
            if (func_reg == FUNC_JOINT)
            begin
                b_reg   <= {16'd0, rate_scale_reg};
                neg_reg <= op_neg;
            end
            else
            begin
                b_reg   <= jr_mag;
                neg_reg <= op_neg ^ jr_sel[47];
            end
            if (op_reg[32] != op_reg[31])
            begin
                h_reg <= op_reg[32] ? INT32_MIN : INT32_MAX;
            end
            else
            begin
                h_reg <= op_reg[31:0];
            end
            viol_reg <= slack_sum[64];
        end
    end

    // Multiplier operand slice for this pass
    always_comb
    begin
        case (step_reg)
            2'd0:    mul_b = b_reg[15:0];
            2'd1:    mul_b = b_reg[31:16];
            default: mul_b = b_reg[47:32];
        endcase
    end

    brc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (seq.mac),
        .mul_a (a_reg),
        .mul_b (mul_b),
        .acc   (acc)
    );

    // Write-back values
    assign rate_mag = (|acc[63:47]) ? RATE_MAX : {1'b0, acc[46:0]};
    assign rate_new = neg_reg ? (48'd0 - rate_mag) : rate_mag;
    assign dot_sum  = neg_reg ? ({row_dot_reg[63], row_dot_reg} - {1'b0, acc})
                              : ({row_dot_reg[63], row_dot_reg} + {1'b0, acc});
    assign dot_new  = (dot_sum[64] != dot_sum[63])
                    ? (dot_sum[64] ? INT64_MIN : INT64_MAX) : dot_sum[63:0];

    // Joint rates and row accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOLS; i++)
            begin
                joint_rate_reg[i] <= '0;
            end
            row_dot_reg <= '0;
            arm_nz_reg  <= '0;
        end
        else
        begin
            if (seq.apply_joint)
            begin
                joint_rate_reg[col_idx] <= rate_new;
            end
            if (seq.apply_jac)
            begin
                row_dot_reg <= dot_new;
                if (op_reg != 33'd0)
                begin
                    arm_nz_reg[arm_sel] <= 1'b1;
                end
            end
            if (seq.close_row)
            begin
                row_dot_reg <= '0;
                arm_nz_reg  <= '0;
            end
        end
    end

    // Trackers, one per arm; class zero rows are skipped
    assign row_keep = (klass_reg != 3'd0);
    assign trk_row  = '{headroom: h_reg, klass: klass_reg, pair: pair_reg};

    always_comb
    begin
        trk_ctrl_l.close = seq.close_row && row_keep && arm_nz_reg[0];
        trk_ctrl_l.viol  = viol_reg;
        trk_ctrl_l.clear = seq.emit_l;
        trk_ctrl_r.close = seq.close_row && row_keep && arm_nz_reg[1];
        trk_ctrl_r.viol  = viol_reg;
        trk_ctrl_r.clear = seq.emit_r;
    end

    brc_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trk_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (trk_ctrl_l),
        .row        (trk_row),
        .ok         (rate_scale_reg != 32'd0),
        .corr       (lcorr_reg),
        .corr_thr   (corr_thr_reg),
        .held_limit (held_limit_reg),
        .result     (res_l)
    );

    brc_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trk_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (trk_ctrl_r),
        .row        (trk_row),
        .ok         (rate_scale_reg != 32'd0),
        .corr       (rcorr_reg),
        .corr_thr   (corr_thr_reg),
        .held_limit (held_limit_reg),
        .result     (res_r)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= seq.emit_l || seq.emit_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.emit_l)
        begin
            res_reg  <= res_l;
            arm_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (seq.emit_r)
        begin
            res_reg  <= res_r;
            arm_reg  <= 1'b1;
            last_reg <= 1'b1;
        end
    end

    assign strobe         = strobe_reg;
    assign arm            = arm_reg;
    assign has_row        = res_reg.has_row;
    assign braking        = res_reg.braking;
    assign held           = res_reg.held;
    assign violated_count = res_reg.count;
    assign headroom       = res_reg.headroom;
    assign shown_pair     = res_reg.pair;
    assign shown_class    = res_reg.klass;
    assign last           = last_reg;

    // Checks
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_EMIT_L || state_reg == ST_EMIT_R))
        else $error("result strobe without an emit state");

    a_right_follows_left: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> $past(strobe_reg && !last_reg))
        else $error("right arm result not preceded by left arm result");

    a_mul_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && step_reg == LAST_STEP) |=> (state_reg == ST_DRAIN))
        else $error("multiplier pass count wrong");

endmodule

`default_nettype wire
